// File: src/slr_pkg.sv
// shared types and constants for the shuffled lcg random source
// used by the top level, the constant divider and the checker; depends on nothing
`timescale 1ns / 1ps

package slr_pkg;

   localparam int unsigned SHUFFLE_ENTRIES_DEFAULT = 97;

   // generator value and modulus
   localparam int MOD_W = 20;
   localparam int unsigned LCG_MODULUS = 714025;
   localparam logic [MOD_W-1:0] LCG_MOD = MOD_W'(LCG_MODULUS);
   localparam logic [10:0] LCG_MUL = 11'd1366;
   localparam logic [MOD_W-1:0] LCG_INC = 20'd150889;

   // payload widths
   localparam int SEED_W = 31;
   localparam int RANGE_W = 16;

   // divider: operand width, reciprocal multiply, quotient and partial remainder
   localparam int X_W = 36;
   localparam int XH_SHIFT = 16;
   localparam int XH_W = X_W - XH_SHIFT;
   localparam int RECIP_SHIFT = 24;
   localparam int RECIP_W = 21;
   localparam longint unsigned RECIP_FULL =
      (64'd1 << (XH_SHIFT + RECIP_SHIFT)) / 64'(LCG_MODULUS);
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_FULL);
   localparam int P1_W = XH_W + RECIP_W;
   localparam int Q_W = P1_W - RECIP_SHIFT;
   localparam int R_W = MOD_W + 1;

   // register port
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam logic [CSR_ADDR_W-3:0] CSR_IDX_SEED = 1'b0;
   localparam logic [SEED_W-1:0] SEED_RESET = 31'd1;

   typedef enum logic [2:0] {
      ST_SEED,
      ST_GEN,
      ST_INDEX,
      ST_DIV1,
      ST_DIV2,
      ST_DIV3,
      ST_IDLE,
      ST_READ
   } state_type;

   typedef enum logic [2:0] {
      OP_SEED,
      OP_WARM,
      OP_INDEX,
      OP_NEXT,
      OP_SCALE
   } op_type;

endpackage

// File: src/slr_ram.sv
// generic single-write, single-read ram with registered read data
// stand-alone; used for the shuffle table
`timescale 1ns / 1ps

module slr_ram #(
   parameter int WIDTH = 20,
   parameter int DEPTH = 97
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// File: src/slr_divmod.sv
// pipelined divide and modulo by the generator modulus
// reciprocal multiply, back-multiply, one correction; uses slr_pkg
`timescale 1ns / 1ps

module slr_divmod (
   input  logic                        clock,
   input  logic [slr_pkg::X_W-1:0]     x,
   output logic [slr_pkg::Q_W-1:0]     quot,
   output logic [slr_pkg::MOD_W-1:0]   rem
);

   logic [slr_pkg::P1_W-1:0]  prod1;
   logic [slr_pkg::Q_W-1:0]   q0_ff;
   logic [slr_pkg::R_W-1:0]   xlo_ff;
   logic [slr_pkg::Q_W+slr_pkg::MOD_W-1:0] prod2;
   logic [slr_pkg::R_W-1:0]   rem0_in;
   logic [slr_pkg::R_W-1:0]   rem0_ff;
   logic [slr_pkg::Q_W-1:0]   q1_ff;
   logic [slr_pkg::R_W-1:0]   rem_fix;
   logic                      fix;

   // estimate is exact or one low
   assign prod1 = slr_pkg::P1_W'(x[slr_pkg::X_W-1:slr_pkg::XH_SHIFT])
                * slr_pkg::P1_W'(slr_pkg::RECIP);

   always_ff @(posedge clock) begin
      q0_ff  <= prod1[slr_pkg::P1_W-1:slr_pkg::RECIP_SHIFT];
      xlo_ff <= x[slr_pkg::R_W-1:0];
   end

   assign prod2 = (slr_pkg::Q_W+slr_pkg::MOD_W)'(q0_ff)
                * (slr_pkg::Q_W+slr_pkg::MOD_W)'(slr_pkg::LCG_MOD);
   // partial remainder lies below twice the modulus, so low bits suffice
   assign rem0_in = xlo_ff - prod2[slr_pkg::R_W-1:0];

   always_ff @(posedge clock) begin
      rem0_ff <= rem0_in;
      q1_ff   <= q0_ff;
   end

   assign fix     = (rem0_ff >= slr_pkg::R_W'(slr_pkg::LCG_MOD));
   assign rem_fix = fix ? (rem0_ff - slr_pkg::R_W'(slr_pkg::LCG_MOD)) : rem0_ff;
   assign rem     = rem_fix[slr_pkg::MOD_W-1:0];
   assign quot    = q1_ff + slr_pkg::Q_W'(fix);

endmodule

// File: src/shuffled_lcg_random.sv
// an accepted item runs ST_READ and ST_DIV1 to ST_DIV3, then its result is registered;
//   ST_DIV3 waits while the result register is full; the item makes three passes through
//   the modulus divider (scaled value, next table index, next generator value), and
//   req_ready stays low until the item is done; reset and every seed write run a warm-up
//   that fills the shuffle table, and req_ready stays low until it ends
// reset is synchronous, active high; uses slr_pkg, slr_ram, slr_divmod
`timescale 1ns / 1ps

module shuffled_lcg_random #(
   parameter int SHUFFLE_ENTRIES = slr_pkg::SHUFFLE_ENTRIES_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [slr_pkg::RANGE_W-1:0]      req_range_max,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [slr_pkg::MOD_W-1:0]        rsp_raw_value,
   output logic [slr_pkg::RANGE_W-1:0]      rsp_scaled_value,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [slr_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [slr_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [slr_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                             pready
);

   localparam int IDX_W = $clog2(SHUFFLE_ENTRIES);
   localparam int CNT_W = $clog2(SHUFFLE_ENTRIES + 1);
   localparam logic [CNT_W-1:0] FILL_DONE = CNT_W'(SHUFFLE_ENTRIES);

   slr_pkg::state_type state_ff, state_in;
   slr_pkg::op_type    op_ff, op_in;

   logic [slr_pkg::SEED_W-1:0]  seed_ff, seed_in, seed_eff;
   logic [slr_pkg::X_W-1:0]     x_ff, x_in;
   logic [slr_pkg::MOD_W-1:0]   gen_ff, gen_in;
   logic [slr_pkg::MOD_W-1:0]   gnext_ff, gnext_in;
   logic [slr_pkg::MOD_W-1:0]   held_ff, held_in;
   logic [IDX_W-1:0]            idx_ff, idx_in;
   logic [CNT_W-1:0]            cnt_ff, cnt_in;
   logic                        warming_ff, warming_in;
   logic [slr_pkg::RANGE_W-1:0] range_ff, range_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [slr_pkg::MOD_W-1:0]   rsp_raw_ff, rsp_raw_in;
   logic [slr_pkg::RANGE_W-1:0] rsp_scaled_ff, rsp_scaled_in;

   logic                        csr_wr;
   logic                        seed_wr;
   logic [slr_pkg::CSR_ADDR_W-3:0] csr_idx;
   logic                        req_accept;
   logic                        rsp_free;

   logic                        wr_en;
   logic [IDX_W-1:0]            wr_addr;
   logic [slr_pkg::MOD_W-1:0]   wr_data;
   logic [slr_pkg::MOD_W-1:0]   rd_data;

   logic [slr_pkg::Q_W-1:0]     div_quot;
   logic [slr_pkg::MOD_W-1:0]   div_rem;

   // register port
   assign pready  = 1'b1;
   assign csr_idx = paddr[slr_pkg::CSR_ADDR_W-1:2];
   assign csr_wr  = psel & penable & pwrite & pready;
   assign seed_wr = csr_wr & (csr_idx == slr_pkg::CSR_IDX_SEED);

   always_comb begin
      prdata = '0;
      if (csr_idx == slr_pkg::CSR_IDX_SEED) begin
         prdata = slr_pkg::CSR_DATA_W'(seed_ff);
      end
   end

   always_comb begin
      seed_in = seed_ff;
      if (seed_wr) begin
         seed_in = pwdata[slr_pkg::SEED_W-1:0];
      end
   end

   assign seed_eff = (seed_ff == '0) ? slr_pkg::SEED_RESET : seed_ff;

   assign req_ready  = (state_ff == slr_pkg::ST_IDLE);
   assign req_accept = req_valid & req_ready;
   assign rsp_free   = ~rsp_valid_ff | rsp_ready;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_raw_value    = rsp_raw_ff;
   assign rsp_scaled_value = rsp_scaled_ff;

   slr_ram #(
      .WIDTH (slr_pkg::MOD_W),
      .DEPTH (SHUFFLE_ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (idx_ff),
      .rd_data (rd_data)
   );

   slr_divmod u_divmod (
      .clock (clock),
      .x     (x_ff),
      .quot  (div_quot),
      .rem   (div_rem)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         slr_pkg::ST_SEED:  state_in = slr_pkg::ST_DIV1;
         slr_pkg::ST_GEN:   state_in = slr_pkg::ST_DIV1;
         slr_pkg::ST_INDEX: state_in = slr_pkg::ST_DIV1;
         slr_pkg::ST_READ:  state_in = slr_pkg::ST_DIV1;
         slr_pkg::ST_DIV1:  state_in = slr_pkg::ST_DIV2;
         slr_pkg::ST_DIV2:  state_in = slr_pkg::ST_DIV3;
         slr_pkg::ST_DIV3: begin
            case (op_ff)
               slr_pkg::OP_SEED:  state_in = slr_pkg::ST_GEN;
               slr_pkg::OP_WARM: begin
                  state_in = (cnt_ff == FILL_DONE) ? slr_pkg::ST_INDEX : slr_pkg::ST_GEN;
               end
               slr_pkg::OP_SCALE: begin
                  // hold here until the result register frees up
                  state_in = rsp_free ? slr_pkg::ST_INDEX : slr_pkg::ST_DIV3;
               end
               slr_pkg::OP_INDEX: state_in = slr_pkg::ST_GEN;
               slr_pkg::OP_NEXT:  state_in = slr_pkg::ST_IDLE;
               default:           state_in = slr_pkg::ST_SEED;
            endcase
         end
         slr_pkg::ST_IDLE: begin
            if (req_accept) begin
               state_in = slr_pkg::ST_READ;
            end
         end
         default: state_in = slr_pkg::ST_SEED;
      endcase
      if (seed_wr) begin
         state_in = slr_pkg::ST_SEED;
      end
   end

   // datapath and table control
   always_comb begin
      op_in         = op_ff;
      x_in          = x_ff;
      gen_in        = gen_ff;
      gnext_in      = gnext_ff;
      held_in       = held_ff;
      idx_in        = idx_ff;
      cnt_in        = cnt_ff;
      warming_in    = warming_ff;
      range_in      = range_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_ready;
      rsp_raw_in    = rsp_raw_ff;
      rsp_scaled_in = rsp_scaled_ff;
      wr_en         = 1'b0;
      wr_addr       = idx_ff;
      wr_data       = gnext_ff;
      case (state_ff)
         slr_pkg::ST_SEED: begin
            x_in       = slr_pkg::X_W'(seed_eff) + slr_pkg::X_W'(slr_pkg::LCG_INC);
            op_in      = slr_pkg::OP_SEED;
            cnt_in     = '0;
            warming_in = 1'b1;
         end
         slr_pkg::ST_GEN: begin
            x_in  = slr_pkg::X_W'(gen_ff) * slr_pkg::X_W'(slr_pkg::LCG_MUL)
                  + slr_pkg::X_W'(slr_pkg::LCG_INC);
            op_in = warming_ff ? slr_pkg::OP_WARM : slr_pkg::OP_NEXT;
         end
         slr_pkg::ST_INDEX: begin
            x_in  = slr_pkg::X_W'(held_ff) * slr_pkg::X_W'(SHUFFLE_ENTRIES);
            op_in = slr_pkg::OP_INDEX;
         end
         slr_pkg::ST_IDLE: begin
            if (req_accept) begin
               range_in = req_range_max;
            end
         end
         slr_pkg::ST_READ: begin
            // table entry becomes the held value, slot takes the prepared generator value
            held_in = rd_data;
            x_in    = slr_pkg::X_W'(rd_data) * slr_pkg::X_W'(range_ff);
            op_in   = slr_pkg::OP_SCALE;
            gen_in  = gnext_ff;
            wr_en   = 1'b1;
         end
         slr_pkg::ST_DIV3: begin
            case (op_ff)
               slr_pkg::OP_SEED: gen_in = div_rem;
               slr_pkg::OP_WARM: begin
                  gen_in = div_rem;
                  if (cnt_ff == FILL_DONE) begin
                     held_in    = div_rem;
                     warming_in = 1'b0;
                  end else begin
                     wr_en   = 1'b1;
                     wr_addr = cnt_ff[IDX_W-1:0];
                     wr_data = div_rem;
                     cnt_in  = cnt_ff + 1'b1;
                  end
               end
               slr_pkg::OP_SCALE: begin
                  if (rsp_free) begin
                     rsp_valid_in  = 1'b1;
                     rsp_raw_in    = held_ff;
                     rsp_scaled_in = div_quot[slr_pkg::RANGE_W-1:0];
                  end
               end
               slr_pkg::OP_INDEX: idx_in   = div_quot[IDX_W-1:0];
               slr_pkg::OP_NEXT:  gnext_in = div_rem;
               default: ;
            endcase
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= slr_pkg::ST_SEED;
         op_ff        <= slr_pkg::OP_SEED;
         seed_ff      <= slr_pkg::SEED_RESET;
         cnt_ff       <= '0;
         warming_ff   <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         seed_ff      <= seed_in;
         cnt_ff       <= cnt_in;
         warming_ff   <= warming_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff          <= x_in;
      gen_ff        <= gen_in;
      gnext_ff      <= gnext_in;
      held_ff       <= held_in;
      idx_ff        <= idx_in;
      range_ff      <= range_in;
      rsp_raw_ff    <= rsp_raw_in;
      rsp_scaled_ff <= rsp_scaled_in;
   end

endmodule

// File: src/slr_checker.sv
// port-level checks for shuffled_lcg_random, bound to the top level
// uses slr_pkg
`timescale 1ns / 1ps

module slr_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_ready,
   input  logic                             rsp_valid,
   input  logic                             rsp_ready,
   input  logic [slr_pkg::MOD_W-1:0]        rsp_raw_value,
   input  logic [slr_pkg::RANGE_W-1:0]      rsp_scaled_value,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [slr_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic                             pready
);

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_raw_value)
                                  && $stable(rsp_scaled_value))
      else $error("result changed while stalled");

   // every value is a residue of the modulus
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_raw_value < slr_pkg::LCG_MOD)
      else $error("raw value out of range");

   // one item at a time
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("item accepted while previous one is in work");

   // a seed write restarts the warm-up
   assert property (@(posedge clock) disable iff (reset)
      psel && penable && pwrite && pready
      && paddr[slr_pkg::CSR_ADDR_W-1:2] == slr_pkg::CSR_IDX_SEED |=> !req_ready)
      else $error("ready after seed write");

endmodule

bind shuffled_lcg_random slr_checker u_checker (.*);
